/* rtl/bbc_pkg.sv */
// Shared types and constants for the one-bit bitmap blit with clipping.
// Used by bbc_lane, bbc_ser and mono_bitmap_blit_clipped_top; no dependencies.
package bbc_pkg;

  localparam int LANES = 8;
  localparam int XW    = 7;   // pixel_x field width
  localparam int YW    = 6;   // pixel_y field width

  // Configuration register indexes.
  localparam logic [2:0] REG_ORIGIN_X      = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y      = 3'd1;
  localparam logic [2:0] REG_IMAGE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_IMAGE_HEIGHT  = 3'd3;
  localparam logic [2:0] REG_LSB_FIRST     = 3'd4;
  localparam logic [2:0] REG_DRAW_POLARITY = 3'd5;

  // Per-byte context that every lane sees.
  typedef struct packed {
    logic [7:0] data;
    logic [4:0] byte_in_row;
    logic [7:0] origin_x;
    logic [7:0] image_width;
    logic       lsb_first;
    logic       draw_polarity;
    logic       row_visible;
  } lane_ctx_t;

  // What one lane found for its bit.
  typedef struct packed {
    logic          hit;
    logic          on;
    logic [XW-1:0] x;
  } lane_res_t;

endpackage

/* rtl/mono_bitmap_blit_clipped_top.sv */
// Top level of the one-bit bitmap blit with clipping: configuration registers,
// row and byte counters, eight bbc_lane instances and the bbc_ser merging stage.
// Depends on bbc_pkg, bbc_lane and bbc_ser.
//
// Usage:
//   The input channel (in_valid / in_stall) carries one word per image byte,
//   rows in order, each row padded to whole bytes; start_of_image clears the
//   row and byte counters before its byte is used. The output channel
//   (out_valid / out_stall) carries one pixel word per unstalled cycle: screen
//   position, value after polarity and a flag on the final pixel of the byte.
//   The first pixel of a byte appears in the cycle after the byte is
//   accepted. A byte yields up to eight pixels, handed out one after the
//   other through the single pixel output; a byte that yields no pixel
//   does not hold the input. The next byte is taken in the cycle the last
//   pixel of the current byte leaves, so the output runs without gaps.
//   When the receiver stalls, the current pixel word holds and in_stall
//   rises until the byte's pixels have drained.
//   Configuration (cfg_we / cfg_index / cfg_data) is written while idle.
//   Synchronous reset restores the register defaults (width and height 16,
//   polarity 1, everything else 0), clears the counters and drops out_valid.
module mono_bitmap_blit_clipped_top #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] image_byte,
  input  logic       start_of_image,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] pixel_x,
  output logic [5:0] pixel_y,
  output logic       pixel_on,
  output logic       last_of_byte
);

  logic [7:0] origin_x;
  logic [7:0] origin_y;
  logic [7:0] image_width;
  logic [7:0] image_height;
  logic       lsb_first;
  logic       draw_polarity;

  logic [7:0] row_count;
  logic [4:0] byte_in_row;
  logic [7:0] row_count_next;
  logic [4:0] byte_in_row_next;

  logic       ready;
  logic       in_accept;
  logic [7:0] row_cur;
  logic [4:0] byte_cur;
  logic       active;
  logic [8:0] screen_y;
  logic [5:0] row_bytes;
  logic       row_end;

  bbc_pkg::lane_ctx_t ctx;
  bbc_pkg::lane_res_t lane_res [bbc_pkg::LANES];

  assign in_stall  = !ready;
  assign in_accept = in_valid && ready;

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= 8'd0;
      origin_y      <= 8'd0;
      image_width   <= 8'd16;
      image_height  <= 8'd16;
      lsb_first     <= 1'b0;
      draw_polarity <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bbc_pkg::REG_ORIGIN_X:      origin_x      <= cfg_data;
        bbc_pkg::REG_ORIGIN_Y:      origin_y      <= cfg_data;
        bbc_pkg::REG_IMAGE_WIDTH:   image_width   <= cfg_data;
        bbc_pkg::REG_IMAGE_HEIGHT:  image_height  <= cfg_data;
        bbc_pkg::REG_LSB_FIRST:     lsb_first     <= cfg_data[0];
        bbc_pkg::REG_DRAW_POLARITY: draw_polarity <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Position of the incoming byte, after an optional restart.
  assign row_cur   = start_of_image ? 8'd0 : row_count;
  assign byte_cur  = start_of_image ? 5'd0 : byte_in_row;
  assign active    = (image_width != 8'd0) && (row_cur < image_height);
  assign screen_y  = {1'b0, origin_y} + {1'b0, row_cur};
  assign row_bytes = 6'(({1'b0, image_width} + 9'd7) >> 3);
  assign row_end   = ({1'b0, byte_cur} + 6'd1) >= row_bytes;

  // Counter advance; a byte past the last row leaves them alone.
  always_comb begin
    row_count_next   = row_cur;
    byte_in_row_next = byte_cur;
    if (active) begin
      if (row_end) begin
        byte_in_row_next = 5'd0;
        row_count_next   = row_cur + 8'd1;
      end else begin
        byte_in_row_next = byte_cur + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count   <= 8'd0;
      byte_in_row <= 5'd0;
    end else if (in_accept) begin
      row_count   <= row_count_next;
      byte_in_row <= byte_in_row_next;
    end
  end

  // Context shared by all lanes.
  always_comb begin
    ctx.data          = image_byte;
    ctx.byte_in_row   = byte_cur;
    ctx.origin_x      = origin_x;
    ctx.image_width   = image_width;
    ctx.lsb_first     = lsb_first;
    ctx.draw_polarity = draw_polarity;
    ctx.row_visible   = active && (screen_y < 9'(SCREEN_HEIGHT));
  end

  for (genvar g = 0; g < bbc_pkg::LANES; g++) begin : g_lane
    bbc_lane #(
      .LANE         (g),
      .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_lane (
      .ctx (ctx),
      .res (lane_res[g])
    );
  end

  bbc_ser u_ser (
    .clk          (clk),
    .rst          (rst),
    .load         (in_accept),
    .lane_res     (lane_res),
    .load_y       (screen_y[bbc_pkg::YW-1:0]),
    .ready        (ready),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .pixel_on     (pixel_on),
    .last_of_byte (last_of_byte)
  );

endmodule

/* rtl/bbc_lane.sv */
// One pixel lane: clips one bit position of the current byte and applies polarity.
// Depends on bbc_pkg.
module bbc_lane #(
  parameter int LANE         = 0,
  parameter int SCREEN_WIDTH = 128
) (
  input  bbc_pkg::lane_ctx_t ctx,
  output bbc_pkg::lane_res_t res
);

  logic [7:0] col;
  logic [8:0] screen_x;
  logic [2:0] pos;
  logic       bit_val;

  // Image column and screen column of this lane's pixel.
  assign col      = {ctx.byte_in_row, 3'(LANE)};
  assign screen_x = {1'b0, ctx.origin_x} + {1'b0, col};

  // Leftmost pixel sits in bit 7 unless the XBM order is selected.
  assign pos     = ctx.lsb_first ? 3'(LANE) : 3'(7 - LANE);
  assign bit_val = ctx.data[pos];

  assign res.hit = ctx.row_visible && (col < ctx.image_width)
                   && (screen_x < 9'(SCREEN_WIDTH));
  assign res.on  = bit_val ^ ~ctx.draw_polarity;
  assign res.x   = screen_x[bbc_pkg::XW-1:0];

endmodule

/* rtl/bbc_ser.sv */
// Merging stage: holds the lane results of one byte and hands out one pixel
// word per cycle while out_stall is low, lowest lane first. Depends on bbc_pkg.
module bbc_ser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  bbc_pkg::lane_res_t           lane_res [bbc_pkg::LANES],
  input  logic [bbc_pkg::YW-1:0]       load_y,
  output logic                         ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bbc_pkg::XW-1:0]       pixel_x,
  output logic [bbc_pkg::YW-1:0]       pixel_y,
  output logic                         pixel_on,
  output logic                         last_of_byte
);

  logic [bbc_pkg::LANES-1:0] mask;
  logic [bbc_pkg::LANES-1:0] on_bits;
  logic [bbc_pkg::XW-1:0]    xs [bbc_pkg::LANES];
  logic [bbc_pkg::YW-1:0]    row_y;

  logic [bbc_pkg::LANES-1:0] pick;
  logic [2:0]                sel;
  logic [bbc_pkg::LANES-1:0] rest;
  logic                      out_accept;

  // Priority pick of the lowest pending lane.
  always_comb begin
    pick = '0;
    sel  = '0;
    for (int i = bbc_pkg::LANES - 1; i >= 0; i--) begin
      if (mask[i]) begin
        pick = '0;
        pick[i] = 1'b1;
        sel = 3'(i);
      end
    end
  end

  assign rest       = mask & ~pick;
  assign out_valid  = |mask;
  assign out_accept = out_valid && !out_stall;
  // A new byte can enter when nothing is pending or the last word leaves now.
  assign ready      = !out_valid || (out_accept && (rest == '0));

  assign pixel_x      = xs[sel];
  assign pixel_y      = row_y;
  assign pixel_on     = on_bits[sel];
  assign last_of_byte = (rest == '0);

  // Pending mask is control state; the rest is payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      for (int i = 0; i < bbc_pkg::LANES; i++) begin
        mask[i] <= lane_res[i].hit;
      end
    end else if (out_accept) begin
      mask <= rest;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      row_y <= load_y;
      for (int i = 0; i < bbc_pkg::LANES; i++) begin
        on_bits[i] <= lane_res[i].on;
        xs[i]      <= lane_res[i].x;
      end
    end
  end

`ifndef SYNTHESIS
  // A byte never overwrites words that are still pending.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (mask == '0 || (out_accept && $onehot(mask))))
    else $error("byte loaded over pending pixel words");

  // The last word of a byte is flagged exactly when one lane remains.
  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_of_byte == $onehot(mask)))
    else $error("last_of_byte does not match pending lanes");

  // After the last word leaves with no new byte, output goes idle.
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (out_accept && last_of_byte && !load) |=> !out_valid)
    else $error("output still valid after last word of byte");
`endif

endmodule
